// File: src/bpe_pkg.sv
// shared types, constants and command codes of the breakpoint envelope generator
package bpe_pkg;

  // table geometry
  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned PIDX_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);

  // fixed point
  localparam int unsigned Q_W     = 17;
  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;
  localparam int unsigned ENTRY_W = 2 * Q_W;

  // divider unit sizes
  localparam int unsigned DIV_N_W    = 40;
  localparam int unsigned DIV_D_W    = 34;
  localparam int unsigned DIV_STEPS  = DIV_N_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int unsigned SUM_W      = DIV_N_W + 1;
  localparam int unsigned TNUM_W     = 39;
  localparam logic [TNUM_W-1:0] TICK_SCALE = 39'd65536000;

  // depth scaling, division by 100 through a reciprocal
  localparam int unsigned PROD_W      = 24;
  localparam logic [6:0]  DEPTH_MAX   = 7'd100;
  localparam logic [PROD_W-1:0] RECIP_100 = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RPROD_W     = 2 * PROD_W;

  // move clamp arithmetic
  localparam int unsigned MV_W = 20;

  // register file
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned RATE_W  = 18;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned DEPTH_W = 7;
  localparam int unsigned GAP_W   = 15;
  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_LEN   = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;
  localparam logic [1:0] REG_GAP   = 2'd3;
  localparam logic [RATE_W-1:0]  RATE_RST  = 18'd48000;
  localparam logic [LEN_W-1:0]   LEN_RST   = 16'd1000;
  localparam logic [LEN_W-1:0]   LEN_MIN   = 16'd10;
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 7'd100;
  localparam logic [GAP_W-1:0]   GAP_RST   = 15'd655;

  // item modes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_NOTE   = 3'd1;
  localparam logic [2:0] MODE_ADD    = 3'd2;
  localparam logic [2:0] MODE_MOVE   = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_CLOSE   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [LEN_W-1:0]   len;
    logic [DEPTH_W-1:0] depth;
    logic [GAP_W-1:0]   gap;
  } cfg_t;

  // commands from the sequencer to the datapath
  typedef enum logic [5:0] {
    CMD_NONE, CMD_INIT0, CMD_INIT1, CMD_LOAD, CMD_TICK_DIV, CMD_TICK_UPD, CMD_NOTE,
    CMD_SET_FULL, CMD_SET_CLOSE, CMD_SET_REFUSED, CMD_WALK_NEXT, CMD_WALK_HIT,
    CMD_SHAPE_RD, CMD_INTERP_FLAT, CMD_INTERP_DIV, CMD_INTERP_UPD, CMD_DEPTH_MUL,
    CMD_DEPTH_DIV, CMD_SCAN_NEXT, CMD_ADD_AT, CMD_SHIFT_INIT, CMD_SH_RD, CMD_SH_WR,
    CMD_ADD_WR, CMD_CNT_IDX, CMD_RM_RD, CMD_RM_WR, CMD_RM_END, CMD_MV_END,
    CMD_MV_RDP, CMD_MV_RDN, CMD_MV_WR, CMD_RESULT
  } cmd_e;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic [2:0] mode;
    logic       running;
    logic       used_full;
    logic       mv_bad;
    logic       mv_end;
    logic       rm_bad;
    logic       hit;
    logic       cnt_zero;
    logic       cnt_last;
    logic       seg_flat;
    logic       add_found;
    logic       add_bad;
    logic       sh_done;
    logic       rm_done;
    logic       div_done;
    logic       out_free;
  } st_t;

endpackage

// File: src/bpe_ram.sv
// generic single write port ram with registered read
module bpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/bpe_div.sv
// restoring divider, one quotient bit per cycle
module bpe_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bpe_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [bpe_pkg::DIV_D_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [bpe_pkg::DIV_N_W-1:0] quotient_o
);
  import bpe_pkg::*;

  logic [DIV_D_W:0]     rem_q, rem_d, trial;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   den_q;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic                 fits;

  // one trial subtraction
  assign trial = {rem_q[DIV_D_W-1:0], quo_q[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? trial - {1'b0, den_q} : trial;
      quo_d  = {quo_q[DIV_N_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/bpe_ctrl.sv
// sequencer that steps the datapath through each item
module bpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  bpe_pkg::st_t  st_i,
  output logic          in_stall_o,
  output bpe_pkg::cmd_e cmd_o
);
  import bpe_pkg::*;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE, S_DISPATCH, S_TDIV, S_WALK, S_WWAIT, S_IPREP, S_IDIV,
    S_DMUL, S_DDIV, S_ASCAN, S_AWAIT, S_ACHK, S_SHRD, S_SHWR, S_RRD, S_RWR, S_MV1,
    S_MV2, S_DONE
  } state_e;

  state_e state_q, state_d;

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_INIT0: begin
        cmd_o   = CMD_INIT0;
        state_d = S_INIT1;
      end
      S_INIT1: begin
        cmd_o   = CMD_INIT1;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_DONE;
        case (st_i.mode)
          MODE_TICK: begin
            if (st_i.running) begin
              cmd_o   = CMD_TICK_DIV;
              state_d = S_TDIV;
            end else begin
              state_d = S_WALK;
            end
          end
          MODE_NOTE: cmd_o = CMD_NOTE;
          MODE_ADD: begin
            if (st_i.used_full) begin
              cmd_o = CMD_SET_FULL;
            end else begin
              state_d = S_ASCAN;
            end
          end
          MODE_MOVE: begin
            if (st_i.mv_bad) begin
              cmd_o = CMD_SET_REFUSED;
            end else if (st_i.mv_end) begin
              cmd_o = CMD_MV_END;
            end else begin
              cmd_o   = CMD_MV_RDP;
              state_d = S_MV1;
            end
          end
          MODE_REMOVE: begin
            if (st_i.rm_bad) begin
              cmd_o = CMD_SET_REFUSED;
            end else begin
              cmd_o   = CMD_CNT_IDX;
              state_d = S_RRD;
            end
          end
          default: cmd_o = CMD_SET_REFUSED;
        endcase
      end
      S_TDIV: begin
        if (st_i.div_done) begin
          cmd_o   = CMD_TICK_UPD;
          state_d = S_WALK;
        end
      end
      // table walk for the shape value
      S_WALK: begin
        if ((st_i.hit && st_i.cnt_zero) || (!st_i.hit && st_i.cnt_last)) begin
          cmd_o   = CMD_SHAPE_RD;
          state_d = S_DMUL;
        end else if (st_i.hit) begin
          cmd_o   = CMD_WALK_HIT;
          state_d = S_IPREP;
        end else begin
          cmd_o   = CMD_WALK_NEXT;
          state_d = S_WWAIT;
        end
      end
      S_WWAIT: state_d = S_WALK;
      S_IPREP: begin
        if (st_i.seg_flat) begin
          cmd_o   = CMD_INTERP_FLAT;
          state_d = S_DMUL;
        end else begin
          cmd_o   = CMD_INTERP_DIV;
          state_d = S_IDIV;
        end
      end
      S_IDIV: begin
        if (st_i.div_done) begin
          cmd_o   = CMD_INTERP_UPD;
          state_d = S_DMUL;
        end
      end
      S_DMUL: begin
        cmd_o   = CMD_DEPTH_MUL;
        state_d = S_DDIV;
      end
      S_DDIV: begin
        cmd_o   = CMD_DEPTH_DIV;
        state_d = S_DONE;
      end
      // insertion point search and shift
      S_ASCAN: begin
        if (st_i.add_found || st_i.cnt_last) begin
          cmd_o   = CMD_ADD_AT;
          state_d = S_ACHK;
        end else begin
          cmd_o   = CMD_SCAN_NEXT;
          state_d = S_AWAIT;
        end
      end
      S_AWAIT: state_d = S_ASCAN;
      S_ACHK: begin
        if (st_i.add_bad) begin
          cmd_o   = CMD_SET_CLOSE;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_SHIFT_INIT;
          state_d = S_SHRD;
        end
      end
      S_SHRD: begin
        if (st_i.sh_done) begin
          cmd_o   = CMD_ADD_WR;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_SH_RD;
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o   = CMD_SH_WR;
        state_d = S_SHRD;
      end
      // removal shift
      S_RRD: begin
        if (st_i.rm_done) begin
          cmd_o   = CMD_RM_END;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_RM_RD;
          state_d = S_RWR;
        end
      end
      S_RWR: begin
        cmd_o   = CMD_RM_WR;
        state_d = S_RRD;
      end
      // inner point move
      S_MV1: begin
        cmd_o   = CMD_MV_RDN;
        state_d = S_MV2;
      end
      S_MV2: begin
        cmd_o   = CMD_MV_WR;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o   = CMD_RESULT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT0;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

// File: src/bpe_dp.sv
// datapath: point table, playhead, arithmetic and result register
module bpe_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpe_pkg::cfg_t                 cfg_i,
  input  bpe_pkg::cmd_e                 cmd_i,
  input  logic [2:0]                    mode_i,
  input  logic [12:0]                   sample_count_i,
  input  logic [3:0]                    point_index_i,
  input  logic [16:0]                   point_time_i,
  input  logic [16:0]                   point_level_i,
  input  logic                          out_stall_i,
  output bpe_pkg::st_t                  st_o,
  output logic                          out_valid_o,
  output logic [16:0]                   mod_value_o,
  output logic [16:0]                   playhead_pos_o,
  output logic                          is_playing_o,
  output logic [3:0]                    entry_index_o,
  output logic [1:0]                    op_status_o,
  output logic [4:0]                    point_count_o
);
  import bpe_pkg::*;

  // item registers
  logic [2:0]        mode_q;
  logic [12:0]       samp_q;
  logic [PIDX_W-1:0] idx_q, at_q, where_q;
  logic [Q_W-1:0]    x_q, y_q;
  logic [1:0]        status_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ENTRY_W-1:0] prev_q, cur_q;
  logic [Q_W-1:0]    shape_q;
  logic [PROD_W-1:0] prod_q;

  // envelope state
  logic [CNT_W-1:0]  used_q;
  logic [Q_W-1:0]    play_q, lvl_q;
  logic              run_q, out_valid_q;

  // table memory
  logic [ENTRY_W-1:0] rd, wdata;
  logic [PIDX_W-1:0]  waddr, raddr;
  logic               we;
  logic [Q_W-1:0]     rd_t, rd_l, prev_t, prev_l, cur_t, cur_l;

  assign rd_t   = rd[ENTRY_W-1 -: Q_W];
  assign rd_l   = rd[Q_W-1:0];
  assign prev_t = prev_q[ENTRY_W-1 -: Q_W];
  assign prev_l = prev_q[Q_W-1:0];
  assign cur_t  = cur_q[ENTRY_W-1 -: Q_W];
  assign cur_l  = cur_q[Q_W-1:0];

  // effective register values
  logic [RATE_W-1:0]  rate_eff;
  logic [LEN_W-1:0]   len_eff;
  logic [DEPTH_W-1:0] depth_eff;
  logic [GAP_W-1:0]   gap_eff;

  assign rate_eff  = (cfg_i.rate == '0) ? RATE_W'(1) : cfg_i.rate;
  assign len_eff   = (cfg_i.len < LEN_MIN) ? LEN_MIN : cfg_i.len;
  assign depth_eff = (cfg_i.depth > DEPTH_MAX) ? DEPTH_MAX : cfg_i.depth;
  assign gap_eff   = (cfg_i.gap == '0) ? GAP_W'(1) : cfg_i.gap;

  // shared divider
  logic [TNUM_W-1:0]  tick_num;
  logic [DIV_D_W-1:0] tick_den;
  logic [Q_W-1:0]     seg_num, seg_dl, seg_dx;
  logic [DIV_D_W-1:0] seg_prod;
  logic [DIV_N_W-1:0] div_n, quo;
  logic [DIV_D_W-1:0] div_d;
  logic               div_start, div_done;

  assign tick_num = TNUM_W'(samp_q) * TICK_SCALE;
  assign tick_den = DIV_D_W'(rate_eff) * DIV_D_W'(len_eff);
  assign seg_num  = play_q - prev_t;
  assign seg_dl   = (cur_l >= prev_l) ? cur_l - prev_l : prev_l - cur_l;
  assign seg_dx   = cur_t - prev_t;
  assign seg_prod = DIV_D_W'(seg_num) * DIV_D_W'(seg_dl);

  assign div_start = (cmd_i == CMD_TICK_DIV) || (cmd_i == CMD_INTERP_DIV);
  assign div_n = (cmd_i == CMD_INTERP_DIV) ? DIV_N_W'(seg_prod) : DIV_N_W'(tick_num);
  assign div_d = (cmd_i == CMD_INTERP_DIV) ? DIV_D_W'(seg_dx) : tick_den;

  bpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // playhead advance with saturation
  logic [SUM_W-1:0] tick_sum;
  logic             tick_end;

  assign tick_sum = SUM_W'(play_q) + SUM_W'(quo);
  assign tick_end = tick_sum >= SUM_W'(ONE_Q16);

  // depth scaling through the reciprocal of 100
  logic [RPROD_W-1:0] recip_prod;

  assign recip_prod = RPROD_W'(prod_q) * RPROD_W'(RECIP_100);

  // add neighbour spacing check
  logic [Q_W-1:0] gap_q16;
  logic           close_prev, close_next;

  assign gap_q16    = Q_W'(gap_eff);
  assign close_prev = (at_q != '0) &&
                      ((x_q >= prev_t && (x_q - prev_t) < gap_q16) || x_q < prev_t);
  assign close_next = (cur_t >= x_q) && ((cur_t - x_q) < gap_q16);

  // move clamp of an inner point
  logic signed [MV_W-1:0] mv_lo, mv_hi, mv_mn, mv_mx, mv_v;
  logic [Q_W-1:0]         mv_nx;

  always_comb begin
    mv_lo = $signed(MV_W'(prev_t)) + $signed(MV_W'(gap_eff));
    mv_hi = $signed(MV_W'(rd_t)) - $signed(MV_W'(gap_eff));
    mv_mn = (mv_lo < mv_hi) ? mv_lo : mv_hi;
    mv_mx = (mv_lo < mv_hi) ? mv_hi : mv_lo;
    mv_v  = $signed(MV_W'(x_q));
    if (mv_v < mv_mn) begin
      mv_v = mv_mn;
    end
    if (mv_v > mv_mx) begin
      mv_v = mv_mx;
    end
    if (mv_v < $signed(MV_W'(0))) begin
      mv_v = '0;
    end
    if (mv_v > $signed(MV_W'(ONE_Q16))) begin
      mv_v = $signed(MV_W'(ONE_Q16));
    end
    mv_nx = mv_v[Q_W-1:0];
  end

  // memory address and write selection
  always_comb begin
    raddr = cnt_q[PIDX_W-1:0];
    we    = 1'b0;
    waddr = idx_q;
    wdata = rd;
    case (cmd_i)
      CMD_SH_RD:  raddr = cnt_q[PIDX_W-1:0] - 1'b1;
      CMD_RM_RD:  raddr = cnt_q[PIDX_W-1:0] + 1'b1;
      CMD_MV_RDP: raddr = idx_q - 1'b1;
      CMD_MV_RDN: raddr = idx_q + 1'b1;
      CMD_INIT0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '0;
      end
      CMD_INIT1: begin
        we    = 1'b1;
        waddr = PIDX_W'(1);
        wdata = {ONE_Q16, ONE_Q16};
      end
      CMD_SH_WR, CMD_RM_WR: begin
        we    = 1'b1;
        waddr = cnt_q[PIDX_W-1:0];
      end
      CMD_ADD_WR: begin
        we    = 1'b1;
        waddr = at_q;
        wdata = {x_q, y_q};
      end
      CMD_MV_END: begin
        we    = 1'b1;
        wdata = {(idx_q == '0) ? Q_W'(0) : ONE_Q16, y_q};
      end
      CMD_MV_WR: begin
        we    = 1'b1;
        wdata = {mv_nx, y_q};
      end
      default: ;
    endcase
  end

  bpe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  // envelope state with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= CNT_W'(2);
      play_q      <= ONE_Q16;
      run_q       <= 1'b0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == CMD_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        CMD_NOTE: begin
          play_q <= '0;
          run_q  <= 1'b1;
        end
        CMD_TICK_UPD: begin
          if (tick_end) begin
            play_q <= ONE_Q16;
            run_q  <= 1'b0;
          end else begin
            play_q <= tick_sum[Q_W-1:0];
          end
        end
        CMD_DEPTH_DIV: lvl_q  <= recip_prod[RECIP_SHIFT +: Q_W];
        CMD_ADD_WR:    used_q <= used_q + 1'b1;
        CMD_RM_END:    used_q <= used_q - 1'b1;
        default: ;
      endcase
    end
  end

  // per item working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        mode_q   <= mode_i;
        samp_q   <= sample_count_i;
        idx_q    <= point_index_i;
        x_q      <= (point_time_i > ONE_Q16) ? ONE_Q16 : point_time_i;
        y_q      <= (point_level_i > ONE_Q16) ? ONE_Q16 : point_level_i;
        cnt_q    <= '0;
        status_q <= ST_OK;
        where_q  <= '0;
      end
      CMD_SET_FULL:    status_q <= ST_FULL;
      CMD_SET_CLOSE:   status_q <= ST_CLOSE;
      CMD_SET_REFUSED: status_q <= ST_REFUSED;
      CMD_WALK_NEXT, CMD_SCAN_NEXT: begin
        prev_q <= rd;
        cnt_q  <= cnt_q + 1'b1;
      end
      CMD_WALK_HIT:    cur_q <= rd;
      CMD_SHAPE_RD:    shape_q <= rd_l;
      CMD_INTERP_FLAT: shape_q <= prev_l;
      CMD_INTERP_UPD: begin
        shape_q <= (cur_l >= prev_l) ? prev_l + quo[Q_W-1:0] : prev_l - quo[Q_W-1:0];
      end
      CMD_DEPTH_MUL: prod_q <= PROD_W'(shape_q) * PROD_W'(depth_eff);
      CMD_ADD_AT: begin
        at_q  <= cnt_q[PIDX_W-1:0];
        cur_q <= rd;
      end
      CMD_SHIFT_INIT: cnt_q   <= used_q;
      CMD_SH_WR:      cnt_q   <= cnt_q - 1'b1;
      CMD_ADD_WR:     where_q <= at_q;
      CMD_CNT_IDX:    cnt_q   <= CNT_W'(idx_q);
      CMD_RM_WR:      cnt_q   <= cnt_q + 1'b1;
      CMD_MV_RDN:     prev_q  <= rd;
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_RESULT) begin
      mod_value_o    <= lvl_q;
      playhead_pos_o <= play_q;
      is_playing_o   <= run_q;
      entry_index_o  <= where_q;
      op_status_o    <= status_q;
      point_count_o  <= used_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // status toward the sequencer
  always_comb begin
    st_o.mode      = mode_q;
    st_o.running   = run_q;
    st_o.used_full = used_q >= CNT_W'(MAX_POINTS);
    st_o.mv_bad    = CNT_W'(idx_q) >= used_q;
    st_o.mv_end    = (idx_q == '0) || (CNT_W'(idx_q) == used_q - 1'b1);
    st_o.rm_bad    = (idx_q == '0) || (CNT_W'(idx_q) + 1'b1 >= used_q);
    st_o.hit       = play_q <= rd_t;
    st_o.cnt_zero  = cnt_q == '0;
    st_o.cnt_last  = cnt_q == used_q - 1'b1;
    st_o.seg_flat  = cur_t <= prev_t;
    st_o.add_found = rd_t >= x_q;
    st_o.add_bad   = close_prev || close_next;
    st_o.sh_done   = cnt_q == CNT_W'(at_q);
    st_o.rm_done   = cnt_q + 1'b1 >= used_q;
    st_o.div_done  = div_done;
    st_o.out_free  = !out_valid_q || !out_stall_i;
  end

`ifndef NO_ASSERTIONS
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q >= CNT_W'(2) && used_q <= CNT_W'(MAX_POINTS))
    else $error("point count out of range");

  a_run_below_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> play_q < ONE_Q16)
    else $error("running with playhead at the end");

  a_values_q16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= ONE_Q16 && play_q <= ONE_Q16)
    else $error("level or playhead above one");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_ADD_WR |=> used_q == $past(used_q) + 1'b1)
    else $error("insert did not grow the table");
`endif

endmodule

// File: src/breakpoint_envelope_generator.sv
// top level of the breakpoint envelope generator: register file and core
//
// Input words arrive on in_valid_i/in_stall_o with mode_i selecting a block tick,
// note-on, point add, point move or point remove. Every accepted word yields one
// result word on out_valid_o/out_stall_i carrying the envelope value, playhead,
// playing flag, insert index, status and point count.
// A running tick takes up to 2 passes of the 40 step restoring divider, one
// for the playhead advance and one for interpolation, plus the table walk;
// walks and shifts go through the table one entry at a time. The divider and
// the table memory, with one read and one write port, set the pace; one word
// is in work at a time.
// A finished result sits in the output register while the next word is taken;
// if the receiver holds out_stall_i, the core waits at the end of that next word.
// After reset the core writes the end points into the table in S_INIT0 and
// S_INIT1 with in_stall_o high; registers reset to 48000 Hz, 1000 ms, 100 %,
// gap 655 (APB at 4*index); the user must write them only while idle, not enforced.
module breakpoint_envelope_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpe_pkg::PADDR_W-1:0]   paddr,
  input  logic [bpe_pkg::PDATA_W-1:0]   pwdata,
  output logic [bpe_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    mode_i,
  input  logic [12:0]                   sample_count_i,
  input  logic [3:0]                    point_index_i,
  input  logic [16:0]                   point_time_i,
  input  logic [16:0]                   point_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [16:0]                   mod_value_o,
  output logic [16:0]                   playhead_pos_o,
  output logic                          is_playing_o,
  output logic [3:0]                    entry_index_o,
  output logic [1:0]                    op_status_o,
  output logic [4:0]                    point_count_o
);
  import bpe_pkg::*;

  cfg_t       cfg_q;
  cmd_e       cmd;
  st_t        st;
  logic       cfg_we;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate  <= RATE_RST;
      cfg_q.len   <= LEN_RST;
      cfg_q.depth <= DEPTH_RST;
      cfg_q.gap   <= GAP_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_RATE:  cfg_q.rate  <= pwdata[RATE_W-1:0];
        REG_LEN:   cfg_q.len   <= pwdata[LEN_W-1:0];
        REG_DEPTH: cfg_q.depth <= pwdata[DEPTH_W-1:0];
        REG_GAP:   cfg_q.gap   <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_RATE:  prdata = PDATA_W'(cfg_q.rate);
      REG_LEN:   prdata = PDATA_W'(cfg_q.len);
      REG_DEPTH: prdata = PDATA_W'(cfg_q.depth);
      REG_GAP:   prdata = PDATA_W'(cfg_q.gap);
      default:   prdata = '0;
    endcase
  end

  bpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .st_i       (st),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  bpe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .mode_i         (mode_i),
    .sample_count_i (sample_count_i),
    .point_index_i  (point_index_i),
    .point_time_i   (point_time_i),
    .point_level_i  (point_level_i),
    .out_stall_i    (out_stall_i),
    .st_o           (st),
    .out_valid_o    (out_valid_o),
    .mod_value_o    (mod_value_o),
    .playhead_pos_o (playhead_pos_o),
    .is_playing_o   (is_playing_o),
    .entry_index_o  (entry_index_o),
    .op_status_o    (op_status_o),
    .point_count_o  (point_count_o)
  );

endmodule
